### hdl/ccr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the contact cluster reducer.
// Used by ccr_ctrl, ccr_dpath and contact_cluster_reducer; depends on nothing else.
package ccr_pkg;

	localparam int MAX_CLUSTERS_DEF     = 8;
	localparam int CLUSTER_CAPACITY_DEF = 32;
	localparam int MAX_CONTACTS_DEF     = 256;

	localparam int IDXW      = 8;     // batch position width
	localparam int THRW      = 15;    // threshold register width
	localparam int PW        = 28;    // projected coordinate width, Q17.10
	localparam int QSHIFT    = 14;    // Q1.14 fraction bits
	localparam int UNIT_ONE  = 16384; // 1.0 in Q1.14
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 15;
	localparam int NCAND      = 5;

	localparam logic [THRW-1:0] COS_THR_RST  = 15'd16220;
	localparam logic [THRW-1:0] VERT_THR_RST = 15'd16368;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic signed [15:0] depth;
		logic               last_contact;
	} contact_t;

	typedef struct packed {
		logic [IDXW-1:0] contact_index;
		logic            last_result;
	} result_t;

	typedef enum logic [1:0] {
		CFG_REDUCE_ENABLE  = 2'd0,
		CFG_COS_THRESHOLD  = 2'd1,
		CFG_VERT_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LOAD,
		OP_SEED,
		OP_MAG,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_WR_BASIS,
		OP_VEC,
		OP_PROJ,
		OP_UPDATE,
		OP_EMIT_PASS,
		OP_CLU_FIRST,
		OP_CLU_NEXT,
		OP_CAND,
		OP_FLUSH
	} dp_op_t;

	typedef enum logic [2:0] {
		M_NONE,
		M_DOT,
		M_SQ,
		M_CRA,
		M_CRB,
		M_PRJ
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		dp_op_t     op;
		mul_sel_t   msel;
		acc_op_t    acc;
		logic [1:0] k;
		logic       j;
		logic [5:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic enable;
		logic table_full;
		logic c_at_end;
		logic match;
		logic cap_full;
		logic end_batch;
		logic out_free;
	} dp_stat_t;

endpackage

### hdl/contact_cluster_reducer.sv
`timescale 1ns / 1ps
// Contact cluster reducer: sorts each batch of contacts into clusters of similar
// normal and, at the end of a batch, keeps per cluster the deepest contact and the
// contacts that bound its 2D box; contacts that find no room, or all when disabled, pass through.
// One contact is in work at a time and the input stalls meanwhile. A pass-through
// waits for a free output register; matching runs per cluster compared three
// products through the single shared multiplier and a compare, joining adds a
// projection and update, and opening a cluster adds, before that same projection
// and update, two vector normalizations that each run a 32-step square root and
// three 15-step divisions. The batch end also waits on the output register.
// Depends on ccr_pkg, ccr_ctrl and ccr_dpath.
module contact_cluster_reducer #(
	parameter int MAX_CLUSTERS     = ccr_pkg::MAX_CLUSTERS_DEF,
	parameter int CLUSTER_CAPACITY = ccr_pkg::CLUSTER_CAPACITY_DEF,
	parameter int MAX_CONTACTS     = ccr_pkg::MAX_CONTACTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     contact_valid,
	output logic                     contact_stall,
	input  ccr_pkg::contact_t        contact,
	output logic                     result_valid,
	input  logic                     result_stall,
	output ccr_pkg::result_t         result,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [ccr_pkg::THRW-1:0] cfg_data
);

	ccr_pkg::dp_cmd_t  dp_cmd;
	ccr_pkg::dp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	ccr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.contact_valid (contact_valid),
		.contact_stall (contact_stall),
		.stat          (dp_stat),
		.cmd           (dp_cmd)
	);

	ccr_dpath #(
		.MAX_CLUSTERS     (MAX_CLUSTERS),
		.CLUSTER_CAPACITY (CLUSTER_CAPACITY),
		.MAX_CONTACTS     (MAX_CONTACTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.contact      (contact),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef ASSERT_OFF
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == ccr_pkg::OP_LOAD) |-> (contact_valid && !contact_stall))
		else $error("contact latched without an accepted beat");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(contact_valid && !contact_stall) |=> contact_stall)
		else $error("input not stalled while a contact is in work");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == ccr_pkg::OP_EMIT_PASS || dp_cmd.op == ccr_pkg::OP_CAND ||
		 dp_cmd.op == ccr_pkg::OP_FLUSH) |-> dp_stat.out_free)
		else $error("result issued while the output register is occupied");
`endif

endmodule

### hdl/ccr_dpath.sv
`timescale 1ns / 1ps
// Datapath of the contact cluster reducer: cluster tables, shared multiplier and
// accumulator, square root and divider steps, result register. Depends on ccr_pkg.
module ccr_dpath #(
	parameter int MAX_CLUSTERS     = ccr_pkg::MAX_CLUSTERS_DEF,
	parameter int CLUSTER_CAPACITY = ccr_pkg::CLUSTER_CAPACITY_DEF,
	parameter int MAX_CONTACTS     = ccr_pkg::MAX_CONTACTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ccr_pkg::dp_cmd_t          cmd,
	output ccr_pkg::dp_stat_t         stat,
	input  ccr_pkg::contact_t         contact,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [ccr_pkg::THRW-1:0]  cfg_data,
	output logic                      result_valid,
	input  logic                      result_stall,
	output ccr_pkg::result_t          result
);

	localparam int CNW = $clog2(MAX_CLUSTERS + 1);
	localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int MW  = $clog2(CLUSTER_CAPACITY + 1);
	localparam int PW  = ccr_pkg::PW;
	localparam int IW  = ccr_pkg::IDXW;

	// configuration
	logic                     enable_q;
	logic [ccr_pkg::THRW-1:0] cos_thr_q;
	logic [ccr_pkg::THRW-1:0] vert_thr_q;

	// batch control
	logic [IW-1:0]  contact_count_q;
	logic [CNW-1:0] cluster_count_q;
	logic [CNW-1:0] c_q;
	logic [CIW-1:0] ci;

	ccr_pkg::contact_t in_q;
	logic [IW-1:0]     idx_q;
	logic              end_q;

	// cluster tables
	logic signed [15:0] cn_q        [MAX_CLUSTERS][3];
	logic signed [15:0] ba_q        [MAX_CLUSTERS][2][3];
	logic [MW-1:0]      members_q   [MAX_CLUSTERS];
	logic signed [PW-1:0] box_q     [MAX_CLUSTERS][4];
	logic signed [15:0] deep_val_q  [MAX_CLUSTERS];
	logic [IW-1:0]      deep_idx_q  [MAX_CLUSTERS];
	logic [IW-1:0]      ext_q       [MAX_CLUSTERS][4];
	logic [IW-1:0]      first_q     [MAX_CLUSTERS];

	// arithmetic
	logic signed [31:0] ma;
	logic signed [31:0] mb;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] vec_q [3];
	logic [30:0]        mag_q [3];
	logic               neg_q [3];
	logic [62:0]        rad_q;
	logic [62:0]        root_q;
	logic [45:0]        rem_q;
	logic [14:0]        quo_q;
	logic signed [15:0] unit_q [3];
	logic signed [PW-1:0] proj_q [2];

	// result path
	logic          out_v_q;
	ccr_pkg::result_t out_q;
	logic          hold_v_q;
	logic [IW-1:0] hold_idx_q;

	logic signed [15:0] nvec [3];
	logic signed [23:0] pvec [3];
	logic signed [31:0] nx32, ny32, nz32;
	logic [16:0]        ay;
	logic               vert;
	logic [31:0]        mabs [3];
	logic               big;
	logic [62:0]        sq_bit;
	logic [62:0]        sq_trial;
	logic [31:0]        len;
	logic [3:0]         div_sh;
	logic [45:0]        div_d;
	logic [14:0]        qclamp;
	logic signed [15:0] qs;
	logic signed [63:0] rsum;
	logic [1:0]         k1;
	logic [1:0]         k2;
	logic [IW-1:0]      cand [ccr_pkg::NCAND];
	logic [IW-1:0]      csel;
	logic               dup;
	logic               push;
	logic [IW-1:0]      push_idx;
	logic               to_hold;
	logic               direct;
	logic               flush;
	logic               out_load;
	ccr_pkg::result_t   out_next;
	logic signed [63:0] thr_w;

	function automatic logic [1:0] nxt(input logic [1:0] k);
		case (k)
			2'd0: nxt = 2'd1;
			2'd1: nxt = 2'd2;
			default: nxt = 2'd0;
		endcase
	endfunction

	assign ci = c_q[CIW-1:0];
	assign nvec[0] = in_q.normal_x;
	assign nvec[1] = in_q.normal_y;
	assign nvec[2] = in_q.normal_z;
	assign pvec[0] = in_q.point_x;
	assign pvec[1] = in_q.point_y;
	assign pvec[2] = in_q.point_z;
	assign nx32 = 32'(in_q.normal_x);
	assign ny32 = 32'(in_q.normal_y);
	assign nz32 = 32'(in_q.normal_z);
	assign ay = in_q.normal_y[15] ? 17'(-(17'(in_q.normal_y))) : 17'(in_q.normal_y);
	assign vert = ay > {2'b00, vert_thr_q};
	assign k1 = nxt(cmd.k);
	assign k2 = nxt(k1);
	assign len = root_q[31:0];

	// Shared multiplier operand selection.
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.msel)
			ccr_pkg::M_DOT: begin
				ma = 32'(nvec[cmd.k]);
				mb = 32'(cn_q[ci][cmd.k]);
			end
			ccr_pkg::M_SQ: begin
				ma = $signed({1'b0, mag_q[cmd.k]});
				mb = $signed({1'b0, mag_q[cmd.k]});
			end
			ccr_pkg::M_CRA: begin
				ma = 32'(nvec[k1]);
				mb = 32'(ba_q[ci][1][k2]);
			end
			ccr_pkg::M_CRB: begin
				ma = 32'(nvec[k2]);
				mb = 32'(ba_q[ci][1][k1]);
			end
			ccr_pkg::M_PRJ: begin
				ma = 32'(ba_q[ci][cmd.j][cmd.k]);
				mb = 32'(pvec[cmd.k]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// Magnitudes for normalization; a large vector is scaled down by four first.
	always_comb begin
		big = 1'b0;
		for (int k = 0; k < 3; k++) begin
			mabs[k] = vec_q[k][31] ? 32'(-vec_q[k]) : 32'(vec_q[k]);
			if (mabs[k] >= 32'h4000_0000)
				big = 1'b1;
		end
	end

	always_comb begin
		sq_bit   = 63'(1) << (6'(62 - 2 * int'(cmd.step)));
		sq_trial = root_q + sq_bit;
		div_sh   = 4'(14 - int'(cmd.step));
		div_d    = 46'(len) << div_sh;
		qclamp   = (quo_q > 15'(ccr_pkg::UNIT_ONE)) ? 15'(ccr_pkg::UNIT_ONE) : quo_q;
		qs       = $signed({1'b0, qclamp});
		rsum     = acc_q + 64'sd8192;
	end

	// Candidates of the current cluster at batch end.
	always_comb begin
		cand[0] = deep_idx_q[ci];
		cand[1] = ext_q[ci][0];
		cand[2] = (box_q[ci][0] == box_q[ci][1]) ? first_q[ci] : ext_q[ci][1];
		cand[3] = ext_q[ci][2];
		cand[4] = (box_q[ci][2] == box_q[ci][3]) ? first_q[ci] : ext_q[ci][3];
		csel = cand[cmd.step[2:0]];
		dup = 1'b0;
		for (int kk = 0; kk < ccr_pkg::NCAND - 1; kk++) begin
			if (3'(kk) < cmd.step[2:0] && cand[kk] == csel)
				dup = 1'b1;
		end
	end

	// Result routing. During the batch-end beat sequence every result waits one
	// step in the hold register so that the final one can be marked.
	always_comb begin
		push     = (cmd.op == ccr_pkg::OP_EMIT_PASS) || (cmd.op == ccr_pkg::OP_CAND && !dup);
		push_idx = (cmd.op == ccr_pkg::OP_EMIT_PASS) ? idx_q : csel;
		to_hold  = push && end_q;
		direct   = push && !end_q;
		flush    = cmd.op == ccr_pkg::OP_FLUSH;
		out_load = direct || ((to_hold || flush) && hold_v_q);
		out_next.contact_index = direct ? push_idx : hold_idx_q;
		out_next.last_result   = flush && !direct;
	end

	assign thr_w = $signed(64'({cos_thr_q, 14'b0}));

	assign stat.enable     = enable_q;
	assign stat.table_full = cluster_count_q >= CNW'(MAX_CLUSTERS);
	assign stat.c_at_end   = c_q == cluster_count_q;
	assign stat.match      = acc_q > thr_w;
	assign stat.cap_full   = members_q[ci] >= MW'(CLUSTER_CAPACITY);
	assign stat.end_batch  = end_q;
	assign stat.out_free   = !out_v_q || !result_stall;

	assign result_valid = out_v_q;
	assign result       = out_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			cos_thr_q       <= ccr_pkg::COS_THR_RST;
			vert_thr_q      <= ccr_pkg::VERT_THR_RST;
			contact_count_q <= '0;
			cluster_count_q <= '0;
			c_q             <= '0;
			out_v_q         <= 1'b0;
			hold_v_q        <= 1'b0;
			for (int c = 0; c < MAX_CLUSTERS; c++)
				members_q[c] <= '0;
		end else begin
			if (cfg_we) begin
				case (ccr_pkg::cfg_reg_t'(cfg_index))
					ccr_pkg::CFG_REDUCE_ENABLE:  enable_q   <= cfg_data[0];
					ccr_pkg::CFG_COS_THRESHOLD:  cos_thr_q  <= cfg_data;
					ccr_pkg::CFG_VERT_THRESHOLD: vert_thr_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load)
				out_v_q <= 1'b1;
			else if (!result_stall)
				out_v_q <= 1'b0;
			if (to_hold)
				hold_v_q <= 1'b1;
			else if (flush)
				hold_v_q <= 1'b0;
			case (cmd.op)
				ccr_pkg::OP_LOAD: begin
					contact_count_q <= contact_count_q + 1'b1;
					c_q             <= '0;
				end
				ccr_pkg::OP_SEED: begin
					cluster_count_q <= cluster_count_q + 1'b1;
					members_q[ci]   <= '0;
				end
				ccr_pkg::OP_UPDATE:    members_q[ci] <= members_q[ci] + 1'b1;
				ccr_pkg::OP_CLU_FIRST: c_q <= '0;
				ccr_pkg::OP_CLU_NEXT:  c_q <= c_q + 1'b1;
				ccr_pkg::OP_FLUSH: begin
					contact_count_q <= '0;
					cluster_count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Payload and arithmetic registers.
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (cmd.acc)
			ccr_pkg::ACC_LOAD: acc_q <= prod_q;
			ccr_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
			ccr_pkg::ACC_SUB:  acc_q <= acc_q - prod_q;
			default: ;
		endcase
		if (out_load)
			out_q <= out_next;
		if (to_hold)
			hold_idx_q <= push_idx;
		case (cmd.op)
			ccr_pkg::OP_LOAD: begin
				in_q  <= contact;
				idx_q <= contact_count_q;
				end_q <= contact.last_contact || (contact_count_q >= IW'(MAX_CONTACTS - 1));
			end
			ccr_pkg::OP_SEED: begin
				cn_q[ci][0] <= in_q.normal_x;
				cn_q[ci][1] <= in_q.normal_y;
				cn_q[ci][2] <= in_q.normal_z;
				vec_q[0] <= vert ? 32'sd0 : (nz32 <<< 14);
				vec_q[1] <= vert ? -(nz32 <<< 14) : 32'sd0;
				vec_q[2] <= vert ? (ny32 <<< 14) : -(nx32 <<< 14);
			end
			ccr_pkg::OP_MAG: begin
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= big ? 31'(mabs[k] >> 2) : 31'(mabs[k]);
					neg_q[k] <= vec_q[k][31];
				end
			end
			ccr_pkg::OP_SQRT_INIT: begin
				rad_q  <= acc_q[62:0];
				root_q <= '0;
			end
			ccr_pkg::OP_SQRT_STEP: begin
				if (rad_q >= sq_trial) begin
					rad_q  <= rad_q - sq_trial;
					root_q <= (root_q >> 1) + sq_bit;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			ccr_pkg::OP_DIV_INIT: begin
				rem_q <= 46'({mag_q[cmd.k], 14'b0}) + 46'(len[31:1]);
				quo_q <= '0;
			end
			ccr_pkg::OP_DIV_STEP: begin
				if (len != '0 && rem_q >= div_d) begin
					rem_q         <= rem_q - div_d;
					quo_q[div_sh] <= 1'b1;
				end
			end
			ccr_pkg::OP_DIV_DONE: unit_q[cmd.k] <= neg_q[cmd.k] ? -qs : qs;
			ccr_pkg::OP_WR_BASIS: begin
				for (int k = 0; k < 3; k++)
					ba_q[ci][cmd.j][k] <= unit_q[k];
			end
			ccr_pkg::OP_VEC:  vec_q[cmd.k] <= acc_q[31:0];
			ccr_pkg::OP_PROJ: proj_q[cmd.j] <= PW'(rsum >>> ccr_pkg::QSHIFT);
			ccr_pkg::OP_UPDATE: begin
				if (members_q[ci] == '0) begin
					for (int kk = 0; kk < 2; kk++) begin
						box_q[ci][2 * kk]     <= proj_q[kk];
						box_q[ci][2 * kk + 1] <= proj_q[kk];
						ext_q[ci][2 * kk]     <= idx_q;
						ext_q[ci][2 * kk + 1] <= idx_q;
					end
					deep_val_q[ci] <= in_q.depth;
					deep_idx_q[ci] <= idx_q;
					first_q[ci]    <= idx_q;
				end else begin
					for (int kk = 0; kk < 2; kk++) begin
						if (proj_q[kk] <= box_q[ci][2 * kk]) begin
							box_q[ci][2 * kk] <= proj_q[kk];
							ext_q[ci][2 * kk] <= idx_q;
						end
						if (proj_q[kk] >= box_q[ci][2 * kk + 1]) begin
							box_q[ci][2 * kk + 1] <= proj_q[kk];
							ext_q[ci][2 * kk + 1] <= idx_q;
						end
					end
					if (in_q.depth > deep_val_q[ci]) begin
						deep_val_q[ci] <= in_q.depth;
						deep_idx_q[ci] <= idx_q;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

### hdl/ccr_ctrl.sv
`timescale 1ns / 1ps
// Controller of the contact cluster reducer: sequences the datapath through
// matching, cluster opening, member update, pass-through and batch-end emission. Depends on ccr_pkg.
module ccr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               contact_valid,
	output logic               contact_stall,
	input  ccr_pkg::dp_stat_t  stat,
	output ccr_pkg::dp_cmd_t   cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_ROUTE, S_DOT, S_CMP, S_SEED, S_MAG, S_SQ, S_SQI, S_SQRT,
		S_DIVI, S_DIV, S_DIVD, S_WRB, S_CROSS, S_PROJ, S_UPD, S_PASS,
		S_ENDI, S_ECHK, S_CAND, S_ENEXT, S_FLUSH
	} state_t;

	state_t     state_q;
	logic [5:0] step_q;
	logic [1:0] k_q;
	logic       sec_q;

	assign contact_stall = state_q != S_IDLE;

	always_comb begin
		cmd      = '0;
		cmd.op   = ccr_pkg::OP_IDLE;
		cmd.msel = ccr_pkg::M_NONE;
		cmd.acc  = ccr_pkg::ACC_HOLD;
		cmd.step = step_q;
		cmd.k    = k_q;
		case (state_q)
			S_IDLE: begin
				if (contact_valid)
					cmd.op = ccr_pkg::OP_LOAD;
			end
			S_DOT, S_SQ, S_PROJ: begin
				if (step_q < 6'd3)
					cmd.msel = (state_q == S_DOT) ? ccr_pkg::M_DOT :
						(state_q == S_SQ) ? ccr_pkg::M_SQ : ccr_pkg::M_PRJ;
				cmd.k = step_q[1:0];
				cmd.j = k_q[0];
				if (step_q == 6'd1)
					cmd.acc = ccr_pkg::ACC_LOAD;
				else if (step_q == 6'd2 || step_q == 6'd3)
					cmd.acc = ccr_pkg::ACC_ADD;
				if (state_q == S_PROJ && step_q == 6'd4)
					cmd.op = ccr_pkg::OP_PROJ;
			end
			S_CMP: begin
				if (!stat.match)
					cmd.op = ccr_pkg::OP_CLU_NEXT;
			end
			S_SEED: cmd.op = ccr_pkg::OP_SEED;
			S_MAG:  cmd.op = ccr_pkg::OP_MAG;
			S_SQI:  cmd.op = ccr_pkg::OP_SQRT_INIT;
			S_SQRT: cmd.op = ccr_pkg::OP_SQRT_STEP;
			S_DIVI: cmd.op = ccr_pkg::OP_DIV_INIT;
			S_DIV:  cmd.op = ccr_pkg::OP_DIV_STEP;
			S_DIVD: cmd.op = ccr_pkg::OP_DIV_DONE;
			S_WRB: begin
				cmd.op = ccr_pkg::OP_WR_BASIS;
				cmd.j  = !sec_q;
			end
			S_CROSS: begin
				// Each component is a difference of two products.
				case (step_q[1:0])
					2'd0: cmd.msel = ccr_pkg::M_CRA;
					2'd1: begin
						cmd.msel = ccr_pkg::M_CRB;
						cmd.acc  = ccr_pkg::ACC_LOAD;
					end
					2'd2: cmd.acc = ccr_pkg::ACC_SUB;
					default: cmd.op = ccr_pkg::OP_VEC;
				endcase
			end
			S_UPD: cmd.op = ccr_pkg::OP_UPDATE;
			S_PASS: begin
				if (stat.out_free)
					cmd.op = ccr_pkg::OP_EMIT_PASS;
			end
			S_ENDI:  cmd.op = ccr_pkg::OP_CLU_FIRST;
			S_CAND: begin
				if (stat.out_free)
					cmd.op = ccr_pkg::OP_CAND;
			end
			S_ENEXT: cmd.op = ccr_pkg::OP_CLU_NEXT;
			S_FLUSH: begin
				if (stat.out_free)
					cmd.op = ccr_pkg::OP_FLUSH;
			end
			default: cmd.op = ccr_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			k_q     <= '0;
			sec_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (contact_valid)
						state_q <= S_ROUTE;
				end
				S_ROUTE: begin
					step_q <= '0;
					if (!stat.enable || stat.table_full)
						state_q <= S_PASS;
					else if (stat.c_at_end)
						state_q <= S_SEED;
					else
						state_q <= S_DOT;
				end
				S_DOT: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd3)
						state_q <= S_CMP;
				end
				S_CMP: begin
					step_q <= '0;
					k_q    <= '0;
					if (!stat.match)
						state_q <= S_ROUTE;
					else if (stat.cap_full)
						state_q <= S_PASS;
					else
						state_q <= S_PROJ;
				end
				S_SEED: begin
					sec_q   <= 1'b0;
					state_q <= S_MAG;
				end
				S_MAG: begin
					step_q  <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd3)
						state_q <= S_SQI;
				end
				S_SQI: begin
					step_q  <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'(ccr_pkg::SQRT_STEPS - 1)) begin
						k_q     <= '0;
						state_q <= S_DIVI;
					end
				end
				S_DIVI: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'(ccr_pkg::DIV_STEPS - 1))
						state_q <= S_DIVD;
				end
				S_DIVD: begin
					if (k_q == 2'd2) begin
						state_q <= S_WRB;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_DIVI;
					end
				end
				S_WRB: begin
					step_q  <= '0;
					k_q     <= '0;
					state_q <= sec_q ? S_PROJ : S_CROSS;
				end
				S_CROSS: begin
					if (step_q[1:0] == 2'd3) begin
						step_q <= '0;
						if (k_q == 2'd2) begin
							sec_q   <= 1'b1;
							state_q <= S_MAG;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_PROJ: begin
					if (step_q == 6'd4) begin
						step_q <= '0;
						if (k_q[0])
							state_q <= S_UPD;
						else
							k_q <= 2'd1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_UPD: state_q <= stat.end_batch ? S_ENDI : S_IDLE;
				S_PASS: begin
					if (stat.out_free)
						state_q <= stat.end_batch ? S_ENDI : S_IDLE;
				end
				S_ENDI: state_q <= S_ECHK;
				S_ECHK: begin
					step_q  <= '0;
					state_q <= stat.c_at_end ? S_FLUSH : S_CAND;
				end
				S_CAND: begin
					if (stat.out_free) begin
						step_q <= step_q + 1'b1;
						if (step_q == 6'(ccr_pkg::NCAND - 1))
							state_q <= S_ENEXT;
					end
				end
				S_ENEXT: state_q <= S_ECHK;
				S_FLUSH: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
